// ===== rtl/core/gtoe_pkg.sv =====
// Shared types, constants and elaboration-time table functions for the geodetic converter.
`timescale 1ns / 1ps

package gtoe_pkg;

  // Field widths of the item channels and the configuration port.
  localparam int LAT_W = 30;
  localparam int LON_W = 31;
  localparam int HGT_W = 31;
  localparam int POS_W = 34;
  localparam int RADIUS_W = 33;
  localparam int ECC_W = 37;
  localparam int CFG_DATA_W = 37;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECC = 1'd1;

  // Register reset values.
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 33'd6378137000;
  localparam logic [ECC_W-1:0] ECC_RESET = 37'd7360548675;

  // Angle constants in input units of 2^-22 degree.
  localparam logic signed [31:0] FULL_TURN = 32'sd1509949440;
  localparam logic [30:0] QUARTER_1 = 31'd377487360;
  localparam logic [30:0] QUARTER_2 = 31'd754974720;
  localparam logic [30:0] QUARTER_3 = 31'd1132462080;

  // Fixed-point constants.
  localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;
  localparam logic [31:0] ONE_Q30_U = 32'd1073741824;
  localparam int NEWTON_STAGES = 5;
  localparam logic signed [37:0] OUT_LIMIT_W = 38'sd8000000000;
  localparam logic signed [POS_W-1:0] OUT_LIMIT = 34'sd8000000000;

  // CORDIC rotation state handed from cell to cell.
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [31:0] z;
  } cordic_t;

  // Newton iteration state: argument w and running estimate y, both Q1.30.
  typedef struct packed {
    logic [31:0] w;
    logic [31:0] y;
  } newton_t;

  // Quadrant numbers of the two angles.
  typedef struct packed {
    logic [1:0] lat_q;
    logic [1:0] lon_q;
  } quad_t;

  // Sines and cosines of both angles, Q1.30.
  typedef struct packed {
    logic signed [31:0] slat;
    logic signed [31:0] clat;
    logic signed [31:0] slon;
    logic signed [31:0] clon;
  } trig_t;

  // Pi/4 in Q62 from Machin's formula.
  function automatic logic [63:0] quarter_pi_q62();
    logic [63:0] t5;
    logic [63:0] s5;
    logic [63:0] t239;
    logic [63:0] s239;
    begin
      t5 = (64'd1 << 62) / 64'd5;
      s5 = 64'd0;
      t239 = (64'd1 << 62) / 64'd239;
      s239 = 64'd0;
      for (int k = 0; k < 32; k++) begin
        if (t5 != 64'd0) begin
          if (k % 2 == 1) s5 = s5 - t5 / 64'(2 * k + 1);
          else s5 = s5 + t5 / 64'(2 * k + 1);
          t5 = t5 / 64'd25;
        end
        if (t239 != 64'd0) begin
          if (k % 2 == 1) s239 = s239 - t239 / 64'(2 * k + 1);
          else s239 = s239 + t239 / 64'(2 * k + 1);
          t239 = t239 / 64'd57121;
        end
      end
      return 64'd4 * s5 - s239;
    end
  endfunction

  localparam logic [63:0] QUARTER_PI_Q62 = quarter_pi_q62();

  // Degree-unit to Q1.30 radian scale, Q32.
  localparam logic [34:0] DEG_SCALE = 35'((QUARTER_PI_Q62 + 64'd45 * (64'd1 << 21))
                                          / (64'd45 * (64'd1 << 22)));

  // Arc tangent of 2^-i in Q1.30, rounded.
  function automatic logic [31:0] atan_q30(input int i);
    logic [63:0] sum;
    int pw;
    begin
      sum = 64'd0;
      if (i == 0) begin
        sum = QUARTER_PI_Q62;
      end else begin
        pw = 62 - i;
        for (int k = 0; k < 64; k++) begin
          if (pw >= 0) begin
            if (k % 2 == 1) sum = sum - (64'd1 << pw) / 64'(2 * k + 1);
            else sum = sum + (64'd1 << pw) / 64'(2 * k + 1);
            pw = pw - 2 * i;
          end
        end
      end
      return 32'((sum + (64'd1 << 31)) >> 32);
    end
  endfunction

  // Squared CORDIC gain in Q60 for n rotations.
  function automatic logic [63:0] gain_sq_q60(input int n);
    logic [63:0] p;
    begin
      p = 64'd1 << 60;
      for (int i = 0; i < n; i++) begin
        if (2 * i < 64) p = p + (p >> (2 * i));
      end
      return p;
    end
  endfunction

  // Integer square root by the digit method.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] bitv;
    begin
      rem = v;
      r = 64'd0;
      bitv = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
        if (bitv > rem) bitv = bitv >> 2;
      end
      for (int j = 0; j < 32; j++) begin
        if (bitv != 64'd0) begin
          if (rem >= r + bitv) begin
            rem = rem - (r + bitv);
            r = (r >> 1) + bitv;
          end else begin
            r = r >> 1;
          end
          bitv = bitv >> 2;
        end
      end
      return r;
    end
  endfunction

endpackage

// ===== rtl/core/gtoe_if.sv =====
// Item channel interfaces: geodetic points in, earth-fixed positions out.
`timescale 1ns / 1ps

interface gtoe_in_if;
  logic valid;
  logic ready;
  logic signed [gtoe_pkg::LAT_W-1:0] latitude;
  logic signed [gtoe_pkg::LON_W-1:0] longitude;
  logic signed [gtoe_pkg::HGT_W-1:0] height_mm;

  modport source (output valid, output latitude, output longitude, output height_mm,
                  input ready);
  modport sink (input valid, input latitude, input longitude, input height_mm,
                output ready);
endinterface

interface gtoe_out_if;
  logic valid;
  logic ready;
  logic signed [gtoe_pkg::POS_W-1:0] pos_x;
  logic signed [gtoe_pkg::POS_W-1:0] pos_y;
  logic signed [gtoe_pkg::POS_W-1:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// ===== rtl/core/geodetic_to_ecef.sv =====
// Top level of the geodetic to earth-fixed position converter.
`timescale 1ns / 1ps

// Converts one geodetic point (latitude and longitude in 2^-22 degree, height in mm)
// per clock into an earth-fixed x, y, z position in mm, saturated to +-8e9 mm. The
// block is a fixed pipeline with one stall enable: it takes a new point every cycle
// as long as the output register is empty or being read. Its depth is set by the
// chain of CORDIC cells (one cell per rotation), the five three-stage Newton cells
// of the inverse square root and the multipliers of the final products.
// The semi-major axis (register 0) and the eccentricity squared (register 1) may be
// written only while no point is in flight.
module geodetic_to_ecef #(
  parameter int CORDIC_STAGES = 30
) (
  input  logic                              clk,
  input  logic                              rst,
  gtoe_in_if.sink                           point,
  gtoe_out_if.source                        position,
  input  logic                              cfg_we,
  input  logic [gtoe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gtoe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int VL = CORDIC_STAGES + 39;
  localparam int HL = CORDIC_STAGES + 33;
  localparam int QL = CORDIC_STAGES + 3;
  localparam int TL = 29;
  localparam int NS = gtoe_pkg::NEWTON_STAGES;
  localparam logic [63:0] GAIN_AMP = gtoe_pkg::isqrt64(gtoe_pkg::gain_sq_q60(CORDIC_STAGES));
  localparam logic [63:0] GAIN_K = ((64'd1 << 60) + GAIN_AMP / 2) / GAIN_AMP;

  logic adv;
  logic [VL:1] vld;

  logic [gtoe_pkg::RADIUS_W-1:0] radius_mm;
  logic [gtoe_pkg::ECC_W-1:0] ecc_sq;
  logic [40:0] ome_full;
  logic [30:0] ome;

  logic signed [31:0] lat_x;
  logic signed [31:0] lon_x;
  logic signed [31:0] lat_sum;
  logic signed [31:0] lon_sum;
  logic [30:0] lat_w;
  logic [30:0] lon_w;
  logic [28:0] lat_r;
  logic [28:0] lon_r;
  logic [1:0] lat_qn;
  logic [1:0] lon_qn;
  logic [30:0] lat_base;
  logic [30:0] lon_base;
  logic signed [31:0] lat_z;
  logic signed [31:0] lon_z;

  logic signed [gtoe_pkg::HGT_W-1:0] h_line [0:HL];
  gtoe_pkg::quad_t q_line [0:QL];
  gtoe_pkg::trig_t trig_line [0:TL];
  gtoe_pkg::cordic_t cord_lat [0:CORDIC_STAGES];
  gtoe_pkg::cordic_t cord_lon [0:CORDIC_STAGES];
  gtoe_pkg::newton_t nwt [0:NS];

  logic signed [32:0] lat_xc;
  logic signed [32:0] lat_yc;
  logic signed [32:0] lon_xc;
  logic signed [32:0] lon_yc;
  gtoe_pkg::trig_t trig_next;

  logic signed [31:0] s2;
  logic signed [31:0] es;
  logic [31:0] w_reg;
  logic signed [35:0] nrad;
  logic signed [35:0] nb;
  logic signed [36:0] nrh;
  logic signed [36:0] nbh;
  logic signed [36:0] r2;
  logic signed [37:0] px;
  logic signed [37:0] py;
  logic signed [37:0] pz;

  // Whole pipeline advances unless a finished item waits at the output.
  assign adv = !vld[VL] || position.ready;
  assign point.ready = adv;
  assign position.valid = vld[VL];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[VL-1:1], point.valid};
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_mm <= gtoe_pkg::RADIUS_RESET;
      ecc_sq <= gtoe_pkg::ECC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gtoe_pkg::REG_RADIUS: radius_mm <= cfg_data[gtoe_pkg::RADIUS_W-1:0];
        gtoe_pkg::REG_ECC: ecc_sq <= cfg_data[gtoe_pkg::ECC_W-1:0];
        default: ;
      endcase
    end
  end

  // One minus e2 in Q1.30, rounded.
  assign ome_full = (41'd1 << 40) - 41'(ecc_sq) + 41'd512;
  assign ome = 31'(ome_full >> 10);

  // Wrap both angles into one full turn.
  assign lat_x = 32'(point.latitude);
  assign lon_x = 32'(point.longitude);
  assign lat_sum = lat_x[31] ? lat_x + gtoe_pkg::FULL_TURN : lat_x;
  assign lon_sum = lon_x[31] ? lon_x + gtoe_pkg::FULL_TURN : lon_x;

  always_ff @(posedge clk) begin
    if (adv) begin
      lat_w <= lat_sum[30:0];
      lon_w <= lon_sum[30:0];
    end
  end

  // Quadrant number and remainder within the quadrant.
  always_comb begin
    if (lat_w >= gtoe_pkg::QUARTER_3) begin
      lat_qn = 2'd3;
      lat_base = gtoe_pkg::QUARTER_3;
    end else if (lat_w >= gtoe_pkg::QUARTER_2) begin
      lat_qn = 2'd2;
      lat_base = gtoe_pkg::QUARTER_2;
    end else if (lat_w >= gtoe_pkg::QUARTER_1) begin
      lat_qn = 2'd1;
      lat_base = gtoe_pkg::QUARTER_1;
    end else begin
      lat_qn = 2'd0;
      lat_base = '0;
    end
    if (lon_w >= gtoe_pkg::QUARTER_3) begin
      lon_qn = 2'd3;
      lon_base = gtoe_pkg::QUARTER_3;
    end else if (lon_w >= gtoe_pkg::QUARTER_2) begin
      lon_qn = 2'd2;
      lon_base = gtoe_pkg::QUARTER_2;
    end else if (lon_w >= gtoe_pkg::QUARTER_1) begin
      lon_qn = 2'd1;
      lon_base = gtoe_pkg::QUARTER_1;
    end else begin
      lon_qn = 2'd0;
      lon_base = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lat_r <= 29'(lat_w - lat_base);
      lon_r <= 29'(lon_w - lon_base);
    end
  end

  // Delay lines for height, quadrant numbers and the sines and cosines.
  always_ff @(posedge clk) begin
    if (adv) begin
      h_line[0] <= point.height_mm;
      q_line[0] <= '{lat_q: lat_qn, lon_q: lon_qn};
      trig_line[0] <= trig_next;
      for (int k = 1; k <= HL; k++) h_line[k] <= h_line[k-1];
      for (int k = 1; k <= QL; k++) q_line[k] <= q_line[k-1];
      for (int k = 1; k <= TL; k++) trig_line[k] <= trig_line[k-1];
    end
  end

  // Angles in Q1.30 radians.
  gtoe_mul_round #(.AW(30), .BW(36), .RW(32), .SHIFT(32)) u_lat_rad (
    .clk(clk), .en(adv), .a({1'b0, lat_r}), .b({1'b0, gtoe_pkg::DEG_SCALE}), .res(lat_z)
  );

  gtoe_mul_round #(.AW(30), .BW(36), .RW(32), .SHIFT(32)) u_lon_rad (
    .clk(clk), .en(adv), .a({1'b0, lon_r}), .b({1'b0, gtoe_pkg::DEG_SCALE}), .res(lon_z)
  );

  // Two CORDIC chains, one cell per rotation.
  assign cord_lat[0] = '{x: 33'(GAIN_K), y: '0, z: lat_z};
  assign cord_lon[0] = '{x: 33'(GAIN_K), y: '0, z: lon_z};

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
    gtoe_cordic_cell #(.STAGE(s)) u_lat_cell (
      .clk(clk), .en(adv), .d_in(cord_lat[s]), .d_out(cord_lat[s+1])
    );
    gtoe_cordic_cell #(.STAGE(s)) u_lon_cell (
      .clk(clk), .en(adv), .d_in(cord_lon[s]), .d_out(cord_lon[s+1])
    );
  end

  // Clamp to one and unfold the quadrant.
  always_comb begin
    lat_xc = cord_lat[CORDIC_STAGES].x;
    lat_yc = cord_lat[CORDIC_STAGES].y;
    lon_xc = cord_lon[CORDIC_STAGES].x;
    lon_yc = cord_lon[CORDIC_STAGES].y;
    if (lat_xc > gtoe_pkg::ONE_Q30) lat_xc = gtoe_pkg::ONE_Q30;
    if (lat_xc < -gtoe_pkg::ONE_Q30) lat_xc = -gtoe_pkg::ONE_Q30;
    if (lat_yc > gtoe_pkg::ONE_Q30) lat_yc = gtoe_pkg::ONE_Q30;
    if (lat_yc < -gtoe_pkg::ONE_Q30) lat_yc = -gtoe_pkg::ONE_Q30;
    if (lon_xc > gtoe_pkg::ONE_Q30) lon_xc = gtoe_pkg::ONE_Q30;
    if (lon_xc < -gtoe_pkg::ONE_Q30) lon_xc = -gtoe_pkg::ONE_Q30;
    if (lon_yc > gtoe_pkg::ONE_Q30) lon_yc = gtoe_pkg::ONE_Q30;
    if (lon_yc < -gtoe_pkg::ONE_Q30) lon_yc = -gtoe_pkg::ONE_Q30;
    case (q_line[QL].lat_q)
      2'd0: begin
        trig_next.clat = 32'(lat_xc);
        trig_next.slat = 32'(lat_yc);
      end
      2'd1: begin
        trig_next.clat = 32'(-lat_yc);
        trig_next.slat = 32'(lat_xc);
      end
      2'd2: begin
        trig_next.clat = 32'(-lat_xc);
        trig_next.slat = 32'(-lat_yc);
      end
      default: begin
        trig_next.clat = 32'(lat_yc);
        trig_next.slat = 32'(-lat_xc);
      end
    endcase
    case (q_line[QL].lon_q)
      2'd0: begin
        trig_next.clon = 32'(lon_xc);
        trig_next.slon = 32'(lon_yc);
      end
      2'd1: begin
        trig_next.clon = 32'(-lon_yc);
        trig_next.slon = 32'(lon_xc);
      end
      2'd2: begin
        trig_next.clon = 32'(-lon_xc);
        trig_next.slon = 32'(-lon_yc);
      end
      default: begin
        trig_next.clon = 32'(lon_yc);
        trig_next.slon = 32'(-lon_xc);
      end
    endcase
  end

  // sin^2 of latitude, then e2 sin^2 with e2 taken in Q34.
  gtoe_mul_round #(.AW(32), .BW(32), .RW(32), .SHIFT(30)) u_sin_sq (
    .clk(clk), .en(adv), .a(trig_line[0].slat), .b(trig_line[0].slat), .res(s2)
  );

  gtoe_mul_round #(.AW(32), .BW(32), .RW(32), .SHIFT(34)) u_ecc_sin (
    .clk(clk), .en(adv), .a({1'b0, ecc_sq[gtoe_pkg::ECC_W-1:6]}), .b(s2), .res(es)
  );

  // Square-root argument 1 - e2 sin^2.
  always_ff @(posedge clk) begin
    if (adv) begin
      w_reg <= gtoe_pkg::ONE_Q30_U - 32'(es);
    end
  end

  // Newton chain for 1 / sqrt(w), starting from one.
  assign nwt[0] = '{w: w_reg, y: gtoe_pkg::ONE_Q30_U};

  for (genvar n = 0; n < NS; n++) begin : g_newton
    gtoe_newton_cell u_newton (
      .clk(clk), .en(adv), .d_in(nwt[n]), .d_out(nwt[n+1])
    );
  end

  // Prime vertical radius N in whole mm.
  gtoe_mul_round #(.AW(34), .BW(33), .RW(36), .SHIFT(30)) u_nrad (
    .clk(clk), .en(adv), .a({1'b0, radius_mm}), .b({1'b0, nwt[NS].y}), .res(nrad)
  );

  // N (1 - e2) for the polar term.
  gtoe_mul_round #(.AW(36), .BW(32), .RW(36), .SHIFT(30)) u_nb (
    .clk(clk), .en(adv), .a(nrad), .b({1'b0, ome}), .res(nb)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      nrh <= 37'(nrad) + 37'(h_line[CORDIC_STAGES + 30]);
      nbh <= 37'(nb) + 37'(h_line[CORDIC_STAGES + 33]);
    end
  end

  // Equatorial-plane radius (N + h) cos lat.
  gtoe_mul_round #(.AW(37), .BW(32), .RW(37), .SHIFT(30)) u_r2 (
    .clk(clk), .en(adv), .a(nrh), .b(trig_line[26].clat), .res(r2)
  );

  // Final coordinates.
  gtoe_mul_round #(.AW(37), .BW(32), .RW(38), .SHIFT(30)) u_px (
    .clk(clk), .en(adv), .a(r2), .b(trig_line[TL].clon), .res(px)
  );

  gtoe_mul_round #(.AW(37), .BW(32), .RW(38), .SHIFT(30)) u_py (
    .clk(clk), .en(adv), .a(r2), .b(trig_line[TL].slon), .res(py)
  );

  gtoe_mul_round #(.AW(37), .BW(32), .RW(38), .SHIFT(30)) u_pz (
    .clk(clk), .en(adv), .a(nbh), .b(trig_line[TL].slat), .res(pz)
  );

  // Saturate into the output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (px > gtoe_pkg::OUT_LIMIT_W) position.pos_x <= gtoe_pkg::OUT_LIMIT;
      else if (px < -gtoe_pkg::OUT_LIMIT_W) position.pos_x <= -gtoe_pkg::OUT_LIMIT;
      else position.pos_x <= px[gtoe_pkg::POS_W-1:0];
      if (py > gtoe_pkg::OUT_LIMIT_W) position.pos_y <= gtoe_pkg::OUT_LIMIT;
      else if (py < -gtoe_pkg::OUT_LIMIT_W) position.pos_y <= -gtoe_pkg::OUT_LIMIT;
      else position.pos_y <= py[gtoe_pkg::POS_W-1:0];
      if (pz > gtoe_pkg::OUT_LIMIT_W) position.pos_z <= gtoe_pkg::OUT_LIMIT;
      else if (pz < -gtoe_pkg::OUT_LIMIT_W) position.pos_z <= -gtoe_pkg::OUT_LIMIT;
      else position.pos_z <= pz[gtoe_pkg::POS_W-1:0];
    end
  end

`ifndef SYNTH
  // An accepted item occupies the first pipeline slot in the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.ready |=> vld[1])
    else $error("accepted item did not enter the pipeline");

  // A stalled pipeline keeps every item where it is.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved while stalled");

  // Delivered x and z coordinates stay inside the saturation range.
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    position.valid |-> (position.pos_x <= gtoe_pkg::OUT_LIMIT)
      && (position.pos_x >= -gtoe_pkg::OUT_LIMIT)
      && (position.pos_z <= gtoe_pkg::OUT_LIMIT)
      && (position.pos_z >= -gtoe_pkg::OUT_LIMIT))
    else $error("output beyond saturation range");
`endif

endmodule

// ===== rtl/core/gtoe_mul_round.sv =====
// Three-stage signed multiplier: magnitude product in two partial products, round half up, sign.
`timescale 1ns / 1ps

module gtoe_mul_round #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int RW = 32,
  parameter int SHIFT = 30
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [RW-1:0] res
);

  localparam int LOW_W = 16;
  localparam int SW = AW + BW + 1;
  localparam logic [SW-1:0] RND = SW'(1) << (SHIFT - 1);

  logic [AW-1:0] ma;
  logic [BW-1:0] mb;
  logic [LOW_W+BW-1:0] pp_lo;
  logic [AW-LOW_W+BW-1:0] pp_hi;
  logic neg1;
  logic neg2;
  logic [SW-1:0] sum;
  logic [SW-1:0] sum_sh;
  logic [RW-1:0] mag;

  // Operand magnitudes.
  assign ma = a[AW-1] ? AW'(-a) : AW'(a);
  assign mb = b[BW-1] ? BW'(-b) : BW'(b);

  // Partial products over the low and high part of the first operand.
  always_ff @(posedge clk) begin
    if (en) begin
      pp_lo <= ma[LOW_W-1:0] * mb;
      pp_hi <= ma[AW-1:LOW_W] * mb;
      neg1 <= a[AW-1] ^ b[BW-1];
    end
  end

  // Combine, round and scale the magnitude.
  assign sum = {pp_hi, LOW_W'(0)} + SW'(pp_lo) + RND;
  assign sum_sh = sum >> SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= RW'(sum_sh);
      neg2 <= neg1;
    end
  end

  // Apply the sign, which rounds halves away from zero.
  always_ff @(posedge clk) begin
    if (en) begin
      res <= neg2 ? RW'(-mag) : mag;
    end
  end

endmodule

// ===== rtl/core/gtoe_cordic_cell.sv =====
// One rotation-mode CORDIC cell of the sine and cosine chain.
`timescale 1ns / 1ps

module gtoe_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              en,
  input  gtoe_pkg::cordic_t d_in,
  output gtoe_pkg::cordic_t d_out
);

  localparam logic signed [31:0] ATAN = $signed(gtoe_pkg::atan_q30(STAGE));

  logic signed [32:0] dx;
  logic signed [32:0] dy;

  // Floor shifts of the cross terms.
  assign dx = d_in.y >>> STAGE;
  assign dy = d_in.x >>> STAGE;

  // Rotate toward zero residual angle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (!d_in.z[31]) begin
        d_out.x <= d_in.x - dx;
        d_out.y <= d_in.y + dy;
        d_out.z <= d_in.z - ATAN;
      end else begin
        d_out.x <= d_in.x + dx;
        d_out.y <= d_in.y - dy;
        d_out.z <= d_in.z + ATAN;
      end
    end
  end

endmodule

// ===== rtl/core/gtoe_newton_cell.sv =====
// One Newton step of the inverse square root, y = y (3 - w y^2) / 2, over three registered stages.
`timescale 1ns / 1ps

module gtoe_newton_cell (
  input  logic              clk,
  input  logic              en,
  input  gtoe_pkg::newton_t d_in,
  output gtoe_pkg::newton_t d_out
);

  localparam logic [63:0] RND29 = 64'd1 << 29;
  localparam logic [63:0] RND30 = 64'd1 << 30;
  localparam logic [33:0] THREE_Q30 = 34'd3 << 30;

  logic [31:0] y_a;
  logic [31:0] w_a;
  logic [31:0] y2_a;
  logic [31:0] y_b;
  logic [31:0] w_b;
  logic [31:0] t_b;
  logic [63:0] y2_full;
  logic [63:0] wy2_full;
  logic [33:0] wy2;
  logic [63:0] yt_full;

  // Square of the estimate.
  assign y2_full = 64'(d_in.y) * 64'(d_in.y) + RND29;

  always_ff @(posedge clk) begin
    if (en) begin
      y_a <= d_in.y;
      w_a <= d_in.w;
      y2_a <= 32'(y2_full >> 30);
    end
  end

  // Scale by w and form 3 - w y^2, held at zero from below.
  assign wy2_full = 64'(w_a) * 64'(y2_a) + RND29;
  assign wy2 = 34'(wy2_full >> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      y_b <= y_a;
      w_b <= w_a;
      t_b <= (wy2 > THREE_Q30) ? 32'd0 : 32'(THREE_Q30 - wy2);
    end
  end

  // New estimate, halved with rounding.
  assign yt_full = 64'(y_b) * 64'(t_b) + RND30;

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.w <= w_b;
      d_out.y <= 32'(yt_full >> 31);
    end
  end

endmodule
